>>> rtl/core/ohlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ohlc_pkg
// Shared widths, constants and types of the one-second OHLC bar builder.
// ============================================================================
package ohlc_pkg;

    // Field widths of the quote and bar items.
    localparam int unsigned TS_W    = 64;
    localparam int unsigned PRICE_W = 64;
    localparam int unsigned QTY_W   = 32;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned SEC_W   = 35;

    // One second is 10^9 ns = 2^9 * 5^9. The low nine bits are shifted away
    // and the rest is divided by 5^9 through a reciprocal multiply.
    localparam int unsigned NS_SHIFT  = 9;
    localparam int unsigned DIVIDEND_W = TS_W - NS_SHIFT;
    localparam int unsigned DIVISOR_W = 21;
    localparam logic [DIVISOR_W-1:0] SEC_DIVISOR = 21'd1953125;

    // floor(2^55 / 5^9), which equals floor(2^64 / 10^9).
    localparam int unsigned RECIP_W = 35;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 35'd18446744073;

    // The remainder after the estimate stays below twice the divisor.
    localparam int unsigned REM_W  = 22;
    localparam int unsigned PROD_W = 90;

    // Cycles from an accepted item to its second at the divider output.
    localparam int unsigned DIV_LAT = 4;

    // Result queue between the bar update and the output port.
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_PTR_W = 3;
    localparam int unsigned FIFO_CNT_W = 4;

    // One open bar of a series, as held in the bar memory.
    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
    } bar_t;

    // One emitted bar, tagged with its series.
    typedef struct packed {
        logic               side;
        logic [LEVEL_W-1:0] level;
        bar_t               bar;
    } res_t;

endpackage
`default_nettype wire

>>> rtl/core/ohlc_quote_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ohlc_quote_if
// Valid/ready channel that carries quote and flush items.
// ============================================================================
interface ohlc_quote_if
    import ohlc_pkg::*;
    ();

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [TS_W-1:0]           timestamp_ns;
    logic                      side;
    logic [LEVEL_W-1:0]        level;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          quantity;

    modport source (
        output valid,
        output kind,
        output timestamp_ns,
        output side,
        output level,
        output price,
        output quantity,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  timestamp_ns,
        input  side,
        input  level,
        input  price,
        input  quantity,
        output ready
    );

endinterface
`default_nettype wire

>>> rtl/core/ohlc_bar_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ohlc_bar_if
// Valid/ready channel that carries finished OHLC bar items.
// ============================================================================
interface ohlc_bar_if
    import ohlc_pkg::*;
    ();

    logic                      valid;
    logic                      ready;
    logic                      out_side;
    logic [LEVEL_W-1:0]        out_level;
    logic [SEC_W-1:0]          bar_second;
    logic signed [PRICE_W-1:0] open_price;
    logic signed [PRICE_W-1:0] high_price;
    logic signed [PRICE_W-1:0] low_price;
    logic signed [PRICE_W-1:0] close_price;

    modport source (
        output valid,
        output out_side,
        output out_level,
        output bar_second,
        output open_price,
        output high_price,
        output low_price,
        output close_price,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_side,
        input  out_level,
        input  bar_second,
        input  open_price,
        input  high_price,
        input  low_price,
        input  close_price,
        output ready
    );

endinterface
`default_nettype wire

>>> rtl/core/ohlc_sec_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ohlc_sec_div
// Four-stage pipelined division of a nanosecond timestamp by 10^9.
// ============================================================================
module ohlc_sec_div
    import ohlc_pkg::*;
(
    input  logic             clk,
    input  logic [TS_W-1:0]  timestamp_ns,
    output logic [SEC_W-1:0] sec
);

    logic [DIVIDEND_W-1:0] dividend;
    logic [31:0]           x_lo;
    logic [DIVIDEND_W-33:0] x_hi;
    logic [PROD_W-1:0]     prod_sum;
    logic [42:0]           back_mul;
    logic [REM_W-1:0]      remainder;

    // Stage one: partial products of the reciprocal multiply.
    logic [63:0]           pp_ll_reg;
    logic [34:0]           pp_lh_reg;
    logic [54:0]           pp_hl_reg;
    logic [25:0]           pp_hh_reg;
    logic [REM_W-1:0]      x1_reg;

    // Stage two: quotient estimate, at most one below the true quotient.
    logic [SEC_W-1:0]      q2_reg;
    logic [REM_W-1:0]      x2_reg;

    // Stage three: low bits of estimate times divisor.
    logic [SEC_W-1:0]      q3_reg;
    logic [REM_W-1:0]      x3_reg;
    logic [REM_W-1:0]      prod3_reg;

    // Stage four: corrected quotient.
    logic [SEC_W-1:0]      sec_reg;

    assign dividend = timestamp_ns[TS_W-1:NS_SHIFT];
    assign x_lo     = dividend[31:0];
    assign x_hi     = dividend[DIVIDEND_W-1:32];

    // Sum of the partial products; the quotient estimate is the top bits.
    assign prod_sum = PROD_W'(pp_ll_reg)
                    + (PROD_W'(pp_lh_reg) << 32)
                    + (PROD_W'(pp_hl_reg) << 32)
                    + (PROD_W'(pp_hh_reg) << 64);

    // Only the remainder's low bits matter, since it stays below 2^22.
    assign back_mul  = 43'(q2_reg[REM_W-1:0]) * 43'(SEC_DIVISOR);
    assign remainder = x3_reg - prod3_reg;

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= 64'(x_lo) * 64'(SEC_RECIP[31:0]);
        pp_lh_reg <= 35'(x_lo) * 35'(SEC_RECIP[RECIP_W-1:32]);
        pp_hl_reg <= 55'(x_hi) * 55'(SEC_RECIP[31:0]);
        pp_hh_reg <= 26'(x_hi) * 26'(SEC_RECIP[RECIP_W-1:32]);
        x1_reg    <= dividend[REM_W-1:0];

        q2_reg    <= prod_sum[PROD_W-1:PROD_W-SEC_W];
        x2_reg    <= x1_reg;

        q3_reg    <= q2_reg;
        x3_reg    <= x2_reg;
        prod3_reg <= back_mul[REM_W-1:0];

        sec_reg   <= q3_reg + SEC_W'(remainder >= {1'b0, SEC_DIVISOR});
    end

    assign sec = sec_reg;

endmodule
`default_nettype wire

>>> rtl/core/ohlc_bar_builder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ohlc_bar_builder_top
// One-second open/high/low/close bars for bid and ask at LEVELS book levels.
// ============================================================================
// Throughput: one quote or flush item per cycle while input ready is high, set by
// the read-modify-write of the bar memory, which forwards the last written bar to
// the next item. A bar that an item closes passes the divide-by-10^9 pipeline and
// the context stages, is pushed into the result queue and is offered from its head.
// An 8-entry result queue absorbs output stalls; input ready drops only when its
// credits run out. Reset clears the pipeline valids, open-bar flags and queue; the
// bar memory is not cleared and an entry is used only while its bar is open.
module ohlc_bar_builder_top
    import ohlc_pkg::*;
#(
    parameter int unsigned LEVELS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    ohlc_quote_if.sink   quote,
    ohlc_bar_if.source   bar
);

    localparam int unsigned SERIES = 2 * LEVELS;
    localparam int unsigned SIDX_W = (SERIES > 1) ? $clog2(SERIES) : 1;

    // Per-item context that travels alongside the divider.
    typedef struct packed {
        logic               kind;
        logic               side;
        logic [LEVEL_W-1:0] level;
        logic [SIDX_W-1:0]  sidx;
        logic               lvl_ok;
        logic               present;
        logic [PRICE_W-1:0] price;
    } ctx_t;

    logic                  accept;
    ctx_t                  in_ctx;
    ctx_t                  c_reg [DIV_LAT];
    logic [DIV_LAT-1:0]    v_reg;
    ctx_t                  cx;
    logic [SEC_W-1:0]      sec;

    bar_t                  bar_mem [SERIES];
    bar_t                  rd_data_reg;
    logic                  byp_valid_reg;
    logic [SIDX_W-1:0]     byp_addr_reg;
    bar_t                  byp_data_reg;
    bar_t                  cur;

    logic [SERIES-1:0]     active_reg;
    logic [SERIES-1:0]     active_next;
    logic                  act;
    logic                  go;
    logic                  is_flush;
    logic                  is_quote;
    logic                  newer;
    logic                  same;
    logic                  flush_emit;
    logic                  emit;
    logic                  start;
    logic                  upd;
    logic                  wr;
    bar_t                  wr_data;
    res_t                  push_res;

    res_t                  fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;
    logic [FIFO_CNT_W:0]   credit_used;
    res_t                  head;

    // Input decode: series index, level check and absent-quote check.
    always_comb
    begin
        in_ctx.kind    = quote.kind;
        in_ctx.side    = quote.side;
        in_ctx.level   = quote.level;
        in_ctx.sidx    = SIDX_W'(quote.side) * SIDX_W'(LEVELS) + SIDX_W'(quote.level);
        in_ctx.lvl_ok  = (32'(quote.level) < LEVELS);
        in_ctx.present = (quote.price != '0) && (quote.quantity != '0);
        in_ctx.price   = quote.price;
    end

    // Credits: queued results plus items in flight never exceed the queue.
    assign credit_used = (FIFO_CNT_W+1)'(count_reg) + (FIFO_CNT_W+1)'($countones(v_reg));
    assign quote.ready = (credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign accept      = quote.valid && quote.ready;

    // Bar second of each item, aligned with the last context stage.
    ohlc_sec_div u_sec_div (
        .clk          (clk),
        .timestamp_ns (quote.timestamp_ns),
        .sec          (sec)
    );

    // Context pipeline, control part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DIV_LAT-2:0], accept};
        end
    end

    // Context pipeline, payload part.
    always_ff @(posedge clk)
    begin
        c_reg[0] <= in_ctx;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            c_reg[i] <= c_reg[i-1];
        end
    end

    assign cx = c_reg[DIV_LAT-1];

    // Bar memory: read one stage ahead, written back by the update stage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            bar_mem[cx.sidx] <= wr_data;
        end
        rd_data_reg <= bar_mem[c_reg[DIV_LAT-2].sidx];
    end

    // A write in the read cycle is not seen by the read; forward it.
    assign cur = (byp_valid_reg && (byp_addr_reg == cx.sidx)) ? byp_data_reg : rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= wr;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_addr_reg <= cx.sidx;
        byp_data_reg <= wr_data;
    end

    // Bar update: open, fold, close and flush decisions for one item.
    always_comb
    begin
        act        = active_reg[cx.sidx];
        go         = v_reg[DIV_LAT-1] && cx.lvl_ok;
        is_flush   = go && cx.kind;
        is_quote   = go && !cx.kind && cx.present;
        newer      = (sec > cur.sec);
        same       = (sec == cur.sec);
        flush_emit = is_flush && act;
        emit       = flush_emit || (is_quote && act && newer);
        start      = is_quote && (!act || newer);
        upd        = is_quote && act && same;
        wr         = start || upd;

        if (start)
        begin
            wr_data.sec     = sec;
            wr_data.open_p  = cx.price;
            wr_data.high_p  = cx.price;
            wr_data.low_p   = cx.price;
            wr_data.close_p = cx.price;
        end
        else
        begin
            wr_data.sec     = cur.sec;
            wr_data.open_p  = cur.open_p;
            wr_data.high_p  = ($signed(cx.price) > $signed(cur.high_p)) ? cx.price : cur.high_p;
            wr_data.low_p   = ($signed(cx.price) < $signed(cur.low_p)) ? cx.price : cur.low_p;
            wr_data.close_p = cx.price;
        end

        active_next = active_reg;
        if (flush_emit)
        begin
            active_next[cx.sidx] = 1'b0;
        end
        else if (start)
        begin
            active_next[cx.sidx] = 1'b1;
        end

        push_res.side  = cx.side;
        push_res.level = cx.level;
        push_res.bar   = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Result queue.
    assign pop = bar.valid && bar.ready;

    always_comb
    begin
        count_next = count_reg;
        if (emit && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!emit && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (emit)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            fifo_mem[wr_ptr_reg] <= push_res;
        end
    end

    // Output channel, driven from the queue head.
    assign head            = fifo_mem[rd_ptr_reg];
    assign bar.valid       = (count_reg != '0);
    assign bar.out_side    = head.side;
    assign bar.out_level   = head.level;
    assign bar.bar_second  = head.bar.sec;
    assign bar.open_price  = head.bar.open_p;
    assign bar.high_price  = head.bar.high_p;
    assign bar.low_price   = head.bar.low_p;
    assign bar.close_price = head.bar.close_p;

    // A result is only pushed while the queue has room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // Queued results and items in flight stay within the queue depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("credit count exceeds result queue depth");

    // A flush that emits a bar leaves its series with no open bar.
    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        flush_emit |=> !active_reg[$past(cx.sidx)])
        else $error("series still open after flush");

endmodule
`default_nettype wire

>>> sim/ohlc_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ohlc_tb_pkg
// Constants and codes shared by the bar builder testbench and its checker.
// ============================================================================
package ohlc_tb_pkg;

    // Book depth used for the block under test; bid and ask give two series per level.
    localparam int unsigned BOOK_LEVELS = 3;
    localparam int unsigned SERIES      = 2 * BOOK_LEVELS;

    // Nanoseconds in one bar second.
    localparam logic [63:0] NS_PER_SECOND = 64'd1_000_000_000;

    // What an item on the quote channel asks for.
    typedef enum logic {
        ITEM_QUOTE = 1'b0,
        ITEM_FLUSH = 1'b1
    } item_kind_e;

    // Book side of a series.
    typedef enum logic {
        SIDE_BID = 1'b0,
        SIDE_ASK = 1'b1
    } book_side_e;

endpackage

>>> sim/ohlc_bar_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ohlc_bar_checker
// Watches the quote and bar channels, folds every accepted item into its
// own copy of the per-series bars and compares each emitted bar in order.
// ============================================================================
module ohlc_bar_checker
    import ohlc_pkg::*;
    import ohlc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ohlc_quote_if       quote,
    ohlc_bar_if         bar,
    output int unsigned mismatches,
    output int unsigned items_accepted,
    output int unsigned bars_checked,
    output int unsigned bars_pending
);

    // Mismatch lines beyond this count are counted but not printed.
    localparam int unsigned PRINT_CAP = 40;

    // Open bar of each series, indexed by side * BOOK_LEVELS + level.
    logic series_open [SERIES];
    bar_t series_bar  [SERIES];

    // Bars that the accepted items have closed, oldest first.
    res_t closed_bars_q [$];

    initial
    begin
        mismatches     = 0;
        items_accepted = 0;
        bars_checked   = 0;
        bars_pending   = 0;
    end

    // Print one line for a wrong field and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t ns: bar %0d: %s is %0h, expected %0h",
                     $time, bars_checked, what, got, want);
        end
        mismatches++;
    endtask

    // Hand the open bar of a series to the list of closed bars.
    task automatic close_series(input int unsigned s, input logic sd,
                                input logic [LEVEL_W-1:0] lvl);
        res_t done;
        done.side  = sd;
        done.level = lvl;
        done.bar   = series_bar[s];
        closed_bars_q.insert(closed_bars_q.size(), done);
    endtask

    // Open a fresh bar on one price.
    task automatic open_series(input int unsigned s, input logic [SEC_W-1:0] sec,
                               input logic signed [PRICE_W-1:0] px);
        series_open[s]        = 1'b1;
        series_bar[s].sec     = sec;
        series_bar[s].open_p  = px;
        series_bar[s].high_p  = px;
        series_bar[s].low_p   = px;
        series_bar[s].close_p = px;
    endtask

    // Apply one accepted quote or flush item to the series state.
    task automatic fold_item(input logic kind, input logic [TS_W-1:0] ts, input logic sd,
                             input logic [LEVEL_W-1:0] lvl,
                             input logic signed [PRICE_W-1:0] px,
                             input logic [QTY_W-1:0] qty);
        int unsigned s;
        logic [TS_W-1:0] whole_sec;
        logic [SEC_W-1:0] sec;
        // Levels past the book depth are ignored outright.
        if (lvl >= BOOK_LEVELS)
            return;
        s = sd * BOOK_LEVELS + lvl;

        // A flush closes the open bar, if there is one.
        if (kind == ITEM_FLUSH)
        begin
            if (series_open[s])
            begin
                close_series(s, sd, lvl);
                series_open[s] = 1'b0;
            end
            return;
        end

        // An absent price or quantity carries no information.
        if (px == '0 || qty == '0)
            return;
        whole_sec = ts / NS_PER_SECOND;
        sec = whole_sec[SEC_W-1:0];

        if (!series_open[s])
        begin
            open_series(s, sec, px);
        end
        else if (sec == series_bar[s].sec)
        begin
            if (px > $signed(series_bar[s].high_p))
                series_bar[s].high_p = px;
            if (px < $signed(series_bar[s].low_p))
                series_bar[s].low_p = px;
            series_bar[s].close_p = px;
        end
        else if (sec > series_bar[s].sec)
        begin
            close_series(s, sd, lvl);
            open_series(s, sec, px);
        end
        // A quote from an older second is dropped.
    endtask

    // Compare results first, then fold the item of the same edge, since an item
    // never produces its bar in the cycle it is accepted.
    always @(posedge clk)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            foreach (series_open[i])
                series_open[i] = 1'b0;
            closed_bars_q.delete();
        end
        else
        begin
            if (bar.valid && bar.ready)
            begin
                if (closed_bars_q.size() == 0)
                begin
                    report_mismatch("unexpected bar, bar_second", 64'(bar.bar_second), '0);
                end
                else
                begin
                    want = closed_bars_q.pop_front();
                    if (bar.out_side !== want.side)
                        report_mismatch("out_side", 64'(bar.out_side), 64'(want.side));
                    if (bar.out_level !== want.level)
                        report_mismatch("out_level", 64'(bar.out_level), 64'(want.level));
                    if (bar.bar_second !== want.bar.sec)
                        report_mismatch("bar_second", 64'(bar.bar_second), 64'(want.bar.sec));
                    if (bar.open_price !== want.bar.open_p)
                        report_mismatch("open_price", bar.open_price, want.bar.open_p);
                    if (bar.high_price !== want.bar.high_p)
                        report_mismatch("high_price", bar.high_price, want.bar.high_p);
                    if (bar.low_price !== want.bar.low_p)
                        report_mismatch("low_price", bar.low_price, want.bar.low_p);
                    if (bar.close_price !== want.bar.close_p)
                        report_mismatch("close_price", bar.close_price, want.bar.close_p);
                    bars_checked++;
                end
            end

            if (quote.valid && quote.ready)
            begin
                fold_item(quote.kind, quote.timestamp_ns, quote.side, quote.level,
                          quote.price, quote.quantity);
                items_accepted++;
            end
        end
        bars_pending <= closed_bars_q.size();
    end

endmodule

>>> sim/tb_ohlc_bar_builder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ohlc_bar_builder_top
// Drives quote and flush items into the bar builder: a directed opening on
// the edge cases, then random market-like streams under four handshake
// patterns. The checker beside the block predicts and compares every bar.
// ============================================================================
module tb_ohlc_bar_builder_top;
    import ohlc_pkg::*;
    import ohlc_tb_pkg::*;

    localparam int unsigned RESET_CYCLES    = 8;
    localparam int unsigned ITEMS_PER_PHASE = 500;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;

    localparam logic signed [PRICE_W-1:0] PX_MAX = {1'b0, {(PRICE_W-1){1'b1}}};
    localparam logic signed [PRICE_W-1:0] PX_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
    localparam logic [TS_W-1:0]           TS_MAX = '1;
    localparam logic [QTY_W-1:0]          QTY_MAX = '1;

    // Idle and stall percentages of the four random phases.
    localparam int unsigned SEND_IDLE_PCT  [4] = '{0, 80, 0, 22};
    localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 80, 22};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int unsigned sender_idle = 0;
    int unsigned recv_stall  = 0;
    int unsigned idle_cycles = 0;

    int unsigned mismatches;
    int unsigned items_accepted;
    int unsigned bars_checked;
    int unsigned bars_pending;

    // Running position of the random quote stream.
    logic [TS_W-1:0]           stream_ts;
    logic signed [PRICE_W-1:0] stream_px;

    logic bar_ready = 1'b0;

    ohlc_quote_if quote_ch ();
    ohlc_bar_if   bar_ch ();

    assign bar_ch.ready = bar_ready;

    always #2 clk = ~clk;

    ohlc_bar_builder_top #(
        .LEVELS (BOOK_LEVELS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .quote (quote_ch),
        .bar   (bar_ch)
    );

    ohlc_bar_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .quote          (quote_ch),
        .bar            (bar_ch),
        .mismatches     (mismatches),
        .items_accepted (items_accepted),
        .bars_checked   (bars_checked),
        .bars_pending   (bars_pending)
    );

    // Output back-pressure at the rate of the current phase.
    always @(posedge clk)
    begin
        bar_ready <= rst_n && ($urandom_range(99) >= recv_stall);
    end

    // Ends the run when no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (quote_ch.valid && quote_ch.ready) || (bar_ch.valid && bar_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles, %0d bars still expected",
                     idle_cycles, bars_pending);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, after random gaps, and return once the block has taken it with ready high.
    task automatic send_item(input item_kind_e kind, input logic [TS_W-1:0] ts,
                             input logic sd, input logic [LEVEL_W-1:0] lvl,
                             input logic signed [PRICE_W-1:0] px,
                             input logic [QTY_W-1:0] qty);
        while ($urandom_range(99) < sender_idle)
        begin
            quote_ch.valid <= 1'b0;
            @(posedge clk);
        end
        quote_ch.valid        <= 1'b1;
        quote_ch.kind         <= kind;
        quote_ch.timestamp_ns <= ts;
        quote_ch.side         <= sd;
        quote_ch.level        <= lvl;
        quote_ch.price        <= px;
        quote_ch.quantity     <= qty;
        @(posedge clk);
        while (!quote_ch.ready)
            @(posedge clk);
    endtask

    // One random item: mostly a quote walking forward through time around a
    // drifting price, with some flushes and some malformed or stale quotes.
    task automatic send_random_item();
        int unsigned pick;
        int unsigned step;
        logic sd;
        logic [LEVEL_W-1:0] lvl;
        logic signed [PRICE_W-1:0] px;
        logic [QTY_W-1:0] qty;
        logic [TS_W-1:0] ts;
        pick = $urandom_range(99);
        sd   = 1'($urandom_range(1));
        lvl  = 2'($urandom_range(BOOK_LEVELS - 1));
        qty  = ($urandom_range(3) == 0) ? QTY_W'($urandom_range(9, 1))
                                        : QTY_W'($urandom_range(32'hFFFF_FFFF, 1));

        // Move the stream: mostly within the second, sometimes to a later one,
        // rarely to a fresh random point with a fresh price level.
        step = $urandom_range(99);
        if (step == 0)
        begin
            stream_ts = {$urandom, $urandom};
            stream_px = {$urandom, $urandom};
        end
        else if (step < 20)
        begin
            stream_ts = stream_ts + 64'($urandom_range(32'd3_000_000_000, 32'd500_000_000));
        end
        else
        begin
            stream_ts = stream_ts + 64'($urandom_range(40_000_000));
        end
        px = stream_px + 64'($urandom_range(2_000_000)) - 64'd1_000_000;
        if (step < 10)
            stream_px = px;

        if (pick < 5)
        begin
            // Flush of any series, junk in the ignored fields.
            send_item(ITEM_FLUSH, {$urandom, $urandom}, sd, 2'($urandom_range(3)),
                      {$urandom, $urandom}, $urandom);
        end
        else if (pick < 12)
        begin
            // Malformed or stale quotes.
            ts = stream_ts;
            case ($urandom_range(3))
                0: px = '0;
                1: qty = '0;
                2: lvl = 2'(BOOK_LEVELS);
                default: ts = stream_ts - 64'($urandom_range(32'd3_000_000_000,
                                                             32'd1_000_000_000));
            endcase
            send_item(ITEM_QUOTE, ts, sd, lvl, px, qty);
        end
        else
        begin
            send_item(ITEM_QUOTE, stream_ts, sd, lvl, px, qty);
        end
    endtask

    initial
    begin
        quote_ch.valid        = 1'b0;
        quote_ch.kind         = ITEM_QUOTE;
        quote_ch.timestamp_ns = '0;
        quote_ch.side         = SIDE_BID;
        quote_ch.level        = '0;
        quote_ch.price        = '0;
        quote_ch.quantity     = '0;
        stream_ts = {$urandom, $urandom};
        stream_px = {$urandom, $urandom};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flush with nothing open, absent price, absent quantity, bad level.
        send_item(ITEM_FLUSH, 64'd5_000_000_000, SIDE_BID, 2'd0, 64'sd77, 32'd1);
        send_item(ITEM_QUOTE, 64'd5_000_000_000, SIDE_BID, 2'd0, '0, 32'd5);
        send_item(ITEM_QUOTE, 64'd5_000_000_000, SIDE_BID, 2'd0, 64'sd100, '0);
        send_item(ITEM_QUOTE, 64'd5_000_000_000, SIDE_BID, 2'd3, 64'sd100, 32'd5);

        // First quote opens a bar; extremes set high and low; a stale second is
        // dropped; the next second closes the bar; a flush closes the new one.
        send_item(ITEM_QUOTE, 64'd5_000_000_123, SIDE_BID, 2'd0, 64'sd1000, 32'd1);
        send_item(ITEM_QUOTE, 64'd5_000_000_124, SIDE_BID, 2'd0, PX_MAX, QTY_MAX);
        send_item(ITEM_QUOTE, 64'd5_000_000_125, SIDE_BID, 2'd0, PX_MIN, 32'd7);
        send_item(ITEM_QUOTE, 64'd4_999_999_999, SIDE_BID, 2'd0, 64'sd55, 32'd3);
        send_item(ITEM_QUOTE, 64'd5_999_999_999, SIDE_BID, 2'd0, -64'sd1, 32'd2);
        send_item(ITEM_QUOTE, 64'd6_000_000_000, SIDE_BID, 2'd0, 64'sd42, 32'd2);
        send_item(ITEM_FLUSH, TS_MAX, SIDE_BID, 2'd0, PX_MIN, QTY_MAX);
        send_item(ITEM_FLUSH, 64'd0, SIDE_ASK, 2'd3, PX_MAX, QTY_MAX);

        // The largest timestamp gives the largest bar second.
        send_item(ITEM_QUOTE, TS_MAX, SIDE_ASK, 2'd2, PX_MIN + 64'sd1, 32'd1);
        send_item(ITEM_QUOTE, TS_MAX, SIDE_ASK, 2'd2, 64'sd3, 32'd1);
        send_item(ITEM_FLUSH, 64'd0, SIDE_ASK, 2'd2, 64'sd0, 32'd0);

        // Every series opened at time zero, then flushed.
        for (int s = 0; s < SERIES; s++)
        begin
            send_item(ITEM_QUOTE, 64'd0, 1'(s / BOOK_LEVELS), 2'(s % BOOK_LEVELS),
                      {$urandom, $urandom} | 64'd1, $urandom_range(32'hFFFF_FFFF, 1));
        end
        for (int s = 0; s < SERIES; s++)
        begin
            send_item(ITEM_FLUSH, {$urandom, $urandom}, 1'(s / BOOK_LEVELS),
                      2'(s % BOOK_LEVELS), {$urandom, $urandom}, $urandom);
        end

        // Random streams under each handshake pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle = SEND_IDLE_PCT[ph];
            recv_stall  = RECV_STALL_PCT[ph];
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        quote_ch.valid <= 1'b0;

        // Let the last bars come out, then allow for the pipeline depth.
        @(posedge clk);
        while (bars_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d quote and flush items and %0d emitted bars,",
                 items_accepted, bars_checked);
        $display("under free-running, sender-gap, output-stall and mixed handshakes.");
        if (mismatches == 0 && bars_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
